FILE: sv/pwq_pkg.sv
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared types and constants for the priority wait queue.
// ----------------------------------------------------------------------------
package pwq_pkg;

   localparam int MAX_TASKS     = 16;
   localparam int PRIORITY_BITS = 8;

   localparam int ID_COUNT = 16;
   localparam int ID_W     = 4;
   localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W  = 5;
   localparam int PRIO_W   = PRIORITY_BITS;

   localparam int OP_FIELD_W     = 2;
   localparam int PRIO_FIELD_W   = 8;
   localparam int STATUS_FIELD_W = 3;

   typedef enum logic [OP_FIELD_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_POP    = 2'd2,
      OP_REPRIO = 2'd3
   } op_type;

   typedef enum logic [STATUS_FIELD_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_DUP    = 3'd2,
      ST_NOTQ   = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RM_RD,
      S_RM_CHK,
      S_INS_START,
      S_INS_RD,
      S_INS_CHK,
      S_INS_PUT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic            set;
      logic            clr;
      logic [ID_W-1:0] id;
   } track_cmd_type;

endpackage

FILE: sv/pwq_tracker.sv
// ----------------------------------------------------------------------------
// pwq_tracker
// Per-id queued flags and the occupied slot count.
// ----------------------------------------------------------------------------
module pwq_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pwq_pkg::ID_W-1:0]        query_id,
   input  pwq_pkg::track_cmd_type          cmd,
   output logic                            query_hit,
   output logic [pwq_pkg::COUNT_W-1:0]     count
);
   import pwq_pkg::*;

   logic [ID_COUNT-1:0] flag_ff;
   logic [ID_COUNT-1:0] flag_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   always_comb begin
      flag_in  = flag_ff;
      count_in = count_ff;
      if (cmd.set) begin
         flag_in[cmd.id] = 1'b1;
         count_in        = count_ff + 1'b1;
      end else if (cmd.clr) begin
         flag_in[cmd.id] = 1'b0;
         count_in        = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= '0;
         count_ff <= '0;
      end else begin
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

   assign query_hit = flag_ff[query_id];
   assign count     = count_ff;

   a_no_set_and_clr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.set && cmd.clr))
      else $error("set and clear in one cycle");

   a_clr_only_queued: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> flag_ff[cmd.id] && count_ff != '0)
      else $error("clear of an id that is not queued");

   a_set_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.set |-> !flag_ff[cmd.id])
      else $error("set of an id already queued");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(flag_ff))
      else $error("count out of step with flags");

endmodule

FILE: sv/priority_wait_queue_core.sv
// ----------------------------------------------------------------------------
// priority_wait_queue_core
// Stable sorted priority queue of waiting task ids.
// ----------------------------------------------------------------------------
// Slots are held in a single-port-write, registered-read memory, head at slot
// zero, ordered by descending priority with first-in first-out order inside a
// priority. One sequencer walks the slots one at a time; each slot visited is
// read, then compared and shifted. An insert walks from the tail down to its
// place, or goes straight to the put step when the queue is empty. Remove and
// pop walk the whole queue. Reprioritize is a remove followed by an insert on
// the shortened queue, without passing through the idle and finish states in
// between. Rejected items go straight from idle to finish. req_ready is high
// only while no item is in progress; a finished result waits in the output
// register without holding up the next item, unless the result before it is
// still waiting there, in which case the sequencer holds in its last step
// until that one is taken.
// ----------------------------------------------------------------------------
module priority_wait_queue_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pwq_pkg::OP_FIELD_W-1:0]        req_operation,
   input  logic [pwq_pkg::ID_W-1:0]              req_task_id,
   input  logic [pwq_pkg::PRIO_FIELD_W-1:0]      req_priority_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pwq_pkg::STATUS_FIELD_W-1:0]    rsp_status,
   output logic                                  rsp_popped_valid,
   output logic [pwq_pkg::ID_W-1:0]              rsp_popped_task,
   output logic [pwq_pkg::PRIO_FIELD_W-1:0]      rsp_popped_priority,
   output logic [pwq_pkg::COUNT_W-1:0]           rsp_queue_count,
   output logic                                  rsp_queue_empty
);
   import pwq_pkg::*;

   // slot memory
   logic [ID_W-1:0]   slot_task_mem [MAX_TASKS];
   logic [PRIO_W-1:0] slot_prio_mem [MAX_TASKS];
   logic [ID_W-1:0]   rd_task_ff;
   logic [PRIO_W-1:0] rd_prio_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [ID_W-1:0]   wr_task;
   logic [PRIO_W-1:0] wr_prio;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] put_addr_ff, put_addr_in;
   logic              found_ff, found_in;
   status_type        status_ff, status_in;
   logic              out_pv_ff, out_pv_in;
   logic [ID_W-1:0]   out_task_ff, out_task_in;
   logic [PRIO_W-1:0] out_prio_ff, out_prio_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic                      rsp_pv_ff;
   logic [ID_W-1:0]           rsp_task_ff;
   logic [PRIO_W-1:0]         rsp_prio_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_load;

   track_cmd_type      tcmd;
   logic               id_hit;
   logic [COUNT_W-1:0] count;

   logic       accept;
   op_type     req_op;
   logic       rm_last;
   logic       rm_hit;
   logic       ins_stop;
   logic       count_full;

   pwq_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .query_id  (req_task_id),
      .cmd       (tcmd),
      .query_hit (id_hit),
      .count     (count)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign req_op     = op_type'(req_operation);
   assign count_full = int'(count) >= MAX_TASKS;
   assign rm_last    = (idx_ff == SLOT_W'(count - 1'b1));
   assign rm_hit     = !found_ff && ((op_ff == OP_POP) || (rd_task_ff == id_ff));
   assign ins_stop   = (rd_prio_ff >= prio_ff);
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_INSERT: state_in = (id_hit || count_full) ? S_FINISH : S_INS_START;
                  OP_REMOVE: state_in = id_hit ? S_RM_RD : S_FINISH;
                  OP_POP:    state_in = (count == '0) ? S_FINISH : S_RM_RD;
                  OP_REPRIO: state_in = id_hit ? S_RM_RD : S_FINISH;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_RM_RD:     state_in = S_RM_CHK;
         S_RM_CHK: begin
            if (!rm_last) begin
               state_in = S_RM_RD;
            end else begin
               state_in = (op_ff == OP_REPRIO) ? S_INS_START : S_FINISH;
            end
         end
         S_INS_START: state_in = (count == '0) ? S_INS_PUT : S_INS_RD;
         S_INS_RD:    state_in = S_INS_CHK;
         S_INS_CHK: begin
            if (ins_stop || idx_ff == '0) begin
               state_in = S_INS_PUT;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT:   state_in = S_FINISH;
         S_FINISH:    state_in = rsp_load ? S_IDLE : S_FINISH;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in       = op_ff;
      id_in       = id_ff;
      prio_in     = prio_ff;
      idx_in      = idx_ff;
      put_addr_in = put_addr_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      out_pv_in   = out_pv_ff;
      out_task_in = out_task_ff;
      out_prio_in = out_prio_ff;
      rd_addr     = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_task     = rd_task_ff;
      wr_prio     = rd_prio_ff;
      tcmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               id_in       = req_task_id;
               prio_in     = req_priority_req[PRIO_W-1:0];
               idx_in      = '0;
               found_in    = 1'b0;
               out_pv_in   = 1'b0;
               out_task_in = '0;
               out_prio_in = '0;
               status_in   = ST_OK;
               unique case (req_op)
                  OP_INSERT: begin
                     if (id_hit) begin
                        status_in = ST_DUP;
                     end else if (count_full) begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_REMOVE, OP_REPRIO: begin
                     if (!id_hit) begin
                        status_in = ST_NOTQ;
                     end
                  end
                  OP_POP: begin
                     if (count == '0) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_RM_RD: begin
            rd_addr = idx_ff;
         end
         S_RM_CHK: begin
            // close the gap left by the removed slot
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - 1'b1;
            end
            if (rm_hit) begin
               found_in = 1'b1;
               id_in    = rd_task_ff;
               if (op_ff == OP_POP) begin
                  out_pv_in   = 1'b1;
                  out_task_in = rd_task_ff;
                  out_prio_in = rd_prio_ff;
               end
            end
            if (rm_last) begin
               tcmd.clr = 1'b1;
               tcmd.id  = rm_hit ? rd_task_ff : id_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_INS_START: begin
            if (count == '0) begin
               put_addr_in = '0;
            end else begin
               idx_in = SLOT_W'(count - 1'b1);
            end
         end
         S_INS_RD: begin
            rd_addr = idx_ff;
         end
         S_INS_CHK: begin
            if (ins_stop) begin
               put_addr_in = idx_ff + 1'b1;
            end else begin
               // open a gap by moving this slot one back
               wr_en   = 1'b1;
               wr_addr = idx_ff + 1'b1;
               if (idx_ff == '0) begin
                  put_addr_in = '0;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = put_addr_ff;
            wr_task  = id_ff;
            wr_prio  = prio_ff;
            tcmd.set = 1'b1;
            tcmd.id  = id_ff;
         end
         S_FINISH: begin
            rd_addr = idx_ff;
         end
         default: rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_task_mem[wr_addr] <= wr_task;
         slot_prio_mem[wr_addr] <= wr_prio;
      end
      rd_task_ff <= slot_task_mem[rd_addr];
      rd_prio_ff <= slot_prio_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      idx_ff      <= idx_in;
      put_addr_ff <= put_addr_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      out_pv_ff   <= out_pv_in;
      out_task_ff <= out_task_in;
      out_prio_ff <= out_prio_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_pv_ff     <= out_pv_ff;
         rsp_task_ff   <= out_task_ff;
         rsp_prio_ff   <= out_prio_ff;
         rsp_count_ff  <= count;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_valid    = rsp_pv_ff;
   assign rsp_popped_task     = rsp_task_ff;
   assign rsp_popped_priority = PRIO_FIELD_W'(rsp_prio_ff);
   assign rsp_queue_count     = rsp_count_ff;
   assign rsp_queue_empty     = (rsp_count_ff == '0);

   a_shift_not_at_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_CHK && found_ff) |-> idx_ff != '0)
      else $error("shift down from the head slot");

   a_put_has_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_PUT |-> !count_full)
      else $error("insert into a full queue");

   a_pop_reports_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_popped_valid) |-> rsp_status == ST_OK)
      else $error("popped item with error status");

   a_remove_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_CHK && rm_last) |-> (found_ff || rm_hit))
      else $error("queued task not found in slots");

endmodule
